// ===== rtl/ccct_pkg.sv =====
package ccct_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int NCELLS      = 8;
  localparam int CELL_W      = $clog2(NCELLS);
  localparam int ROWS        = (MAX_ENTRIES + NCELLS - 1) / NCELLS;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W       = ROW_W + CELL_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic MODE_SEARCH = 1'b0;
  localparam logic MODE_FETCH  = 1'b1;

  typedef struct packed {
    logic [31:0] symbol;
    logic [31:0] value;
    logic [31:0] next;
    logic [23:0] cum_low;
    logic [15:0] occ;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [CELL_W-1:0] wr_cell;
    logic [CNT_W-1:0] used;
    logic [23:0]      cnt;
    entry_t           wr_data;
  } cell_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } link_t;

  typedef struct packed {
    logic [31:0] symbol;
    logic [31:0] assoc_value;
    logic [31:0] next_context;
    logic [7:0]  entry_index;
    logic [23:0] cum_low;
    logic [15:0] entry_occurrences;
    logic [23:0] total_count;
    logic [1:0]  status;
  } res_t;

  function automatic logic [7:0] idx8(input logic [IDX_W-1:0] idx);
    logic [IDX_W+7:0] w;
    w = {8'd0, idx};
    return w[7:0];
  endfunction

endpackage

// ===== rtl/ccct_if.sv =====
interface ccct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] raw_symbol;
  logic [15:0] occurrence_count;
  logic [31:0] raw_value;
  logic [31:0] next_context_in;
  logic [23:0] lookup_count;

  modport source(output valid, operation, raw_symbol, occurrence_count, raw_value,
                 next_context_in, lookup_count, input ready);
  modport sink(input valid, operation, raw_symbol, occurrence_count, raw_value,
               next_context_in, lookup_count, output ready);
endinterface

interface ccct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] symbol;
  logic signed [31:0] assoc_value;
  logic [31:0]        next_context;
  logic [7:0]         entry_index;
  logic [23:0]        cum_low;
  logic [15:0]        entry_occurrences;
  logic [23:0]        total_count;
  logic [1:0]         status;

  modport source(output valid, symbol, assoc_value, next_context, entry_index, cum_low,
                 entry_occurrences, total_count, status, input ready);
  modport sink(input valid, symbol, assoc_value, next_context, entry_index, cum_low,
               entry_occurrences, total_count, status, output ready);
endinterface

interface ccct_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/ccct_cell.sv =====
module ccct_cell (
  input  logic                        clk,
  input  logic [ccct_pkg::CELL_W-1:0] cell_id,
  input  ccct_pkg::cell_ctl_t         ctl,
  input  ccct_pkg::link_t             link_in,
  output ccct_pkg::link_t             link_out
);

  ccct_pkg::entry_t mem [ccct_pkg::ROWS];
  ccct_pkg::entry_t rd_r;

  logic [ccct_pkg::IDX_W-1:0] idx;
  logic [ccct_pkg::CMP_W-1:0] idx_ext;
  logic [ccct_pkg::CMP_W-1:0] used_ext;
  logic [24:0]                range_end;
  logic                       own_hit;

  // entry i lives in cell i mod NCELLS, row i / NCELLS
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_cell == cell_id)) begin
      mem[ctl.row] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_r <= mem[ctl.row];
    end
  end

  assign idx       = {ctl.row, cell_id};
  assign idx_ext   = ccct_pkg::CMP_W'(idx);
  assign used_ext  = ccct_pkg::CMP_W'(ctl.used);
  assign range_end = {1'b0, rd_r.cum_low} + {9'd0, rd_r.occ};

  always_comb begin
    if (ctl.mode == ccct_pkg::MODE_FETCH) begin
      // fallback: pick the last stored entry
      own_hit = ((idx_ext + ccct_pkg::CMP_W'(1)) == used_ext);
    end else begin
      own_hit = (idx_ext < used_ext) && ({1'b0, ctl.cnt} < range_end);
    end
  end

  // first hit along the chain wins
  always_comb begin
    if (!link_in.hit && own_hit) begin
      link_out.hit   = 1'b1;
      link_out.idx   = idx;
      link_out.entry = rd_r;
    end else begin
      link_out = link_in;
    end
  end

endmodule

// ===== rtl/cumulative_count_context_table_unit.sv =====
// Context table for an arithmetic decoder: clear, append and lookup by cumulative count,
// one item at a time. Entries sit in a row of eight cells, each owning its own small
// entry memory; a lookup reads one row of eight entries from all cells at once and
// resolves the first match along the cell chain, row by row from row 0 (memory read,
// then compare). Clear, append, unused codes and a lookup on an empty table go straight
// to the result register; a lookup that runs past the total (fallback to the last entry)
// rereads the last row to fetch the last entry. The next item is taken in the cycle
// after the result reaches the output register, and min_value applies to appends that
// follow.
module cumulative_count_context_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  ccct_in_if.sink      in_ch,
  ccct_out_if.source   out_ch,
  ccct_cfg_if.sink     cfg_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [ccct_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                       mode_r, mode_nxt;
  logic [ccct_pkg::CNT_W-1:0] used_r, used_nxt;
  logic [23:0]                total_r, total_nxt;
  logic [31:0]                min_value_r;
  logic [23:0]                cnt_r, cnt_nxt;
  ccct_pkg::res_t             res_r, res_nxt;
  ccct_pkg::res_t             out_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;

  logic                       in_xfer;
  logic                       full;
  logic [ccct_pkg::ROW_W-1:0] wr_row;
  logic [ccct_pkg::ROW_W-1:0] last_row;
  ccct_pkg::entry_t           new_entry;
  ccct_pkg::cell_ctl_t        ctl;
  ccct_pkg::link_t            links [ccct_pkg::NCELLS+1];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign full     = (used_r >= ccct_pkg::CNT_W'(ccct_pkg::MAX_ENTRIES));
  assign wr_row   = ccct_pkg::ROW_W'(used_r >> ccct_pkg::CELL_W);
  assign last_row = ccct_pkg::ROW_W'((used_r - ccct_pkg::CNT_W'(1)) >> ccct_pkg::CELL_W);

  assign new_entry.symbol  = in_ch.raw_symbol - 32'd2;
  assign new_entry.value   = in_ch.raw_value + min_value_r;
  assign new_entry.next    = in_ch.next_context_in;
  assign new_entry.cum_low = total_r;
  assign new_entry.occ     = in_ch.occurrence_count;

  always_comb begin
    ctl.rd_en   = (state_r == S_READ);
    ctl.wr_en   = in_xfer && (in_ch.operation == ccct_pkg::OP_APPEND) && !full;
    ctl.mode    = mode_r;
    ctl.row     = (state_r == S_IDLE) ? wr_row : row_r;
    ctl.wr_cell = ccct_pkg::CELL_W'(used_r);
    ctl.used    = used_r;
    ctl.cnt     = cnt_r;
    ctl.wr_data = new_entry;
  end

  assign links[0] = '0;

  for (genvar g = 0; g < ccct_pkg::NCELLS; g++) begin : g_cell
    ccct_cell u_cell (
      .clk      (clk),
      .cell_id  (ccct_pkg::CELL_W'(g)),
      .ctl      (ctl),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    mode_nxt  = mode_r;
    used_nxt  = used_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt             = '0;
          res_nxt.total_count = total_r;
          state_nxt           = S_DONE;
          unique case (in_ch.operation)
            ccct_pkg::OP_CLEAR: begin
              used_nxt            = '0;
              total_nxt           = '0;
              res_nxt.total_count = '0;
            end
            ccct_pkg::OP_APPEND: begin
              if (full) begin
                res_nxt.status = ccct_pkg::ST_FULL;
              end else begin
                used_nxt                  = used_r + ccct_pkg::CNT_W'(1);
                total_nxt                 = total_r + 24'(in_ch.occurrence_count);
                res_nxt.symbol            = new_entry.symbol;
                res_nxt.assoc_value       = new_entry.value;
                res_nxt.next_context      = new_entry.next;
                res_nxt.entry_index       = ccct_pkg::idx8(ccct_pkg::IDX_W'(used_r));
                res_nxt.cum_low           = new_entry.cum_low;
                res_nxt.entry_occurrences = new_entry.occ;
                res_nxt.total_count       = total_r + 24'(in_ch.occurrence_count);
              end
            end
            ccct_pkg::OP_LOOKUP: begin
              if (used_r == '0) begin
                res_nxt.status = ccct_pkg::ST_EMPTY;
              end else begin
                cnt_nxt   = in_ch.lookup_count;
                row_nxt   = '0;
                mode_nxt  = ccct_pkg::MODE_SEARCH;
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (links[ccct_pkg::NCELLS].hit) begin
          res_nxt.symbol            = links[ccct_pkg::NCELLS].entry.symbol;
          res_nxt.assoc_value       = links[ccct_pkg::NCELLS].entry.value;
          res_nxt.next_context      = links[ccct_pkg::NCELLS].entry.next;
          res_nxt.entry_index       = ccct_pkg::idx8(links[ccct_pkg::NCELLS].idx);
          res_nxt.cum_low           = links[ccct_pkg::NCELLS].entry.cum_low;
          res_nxt.entry_occurrences = links[ccct_pkg::NCELLS].entry.occ;
          res_nxt.total_count       = total_r;
          res_nxt.status            = ccct_pkg::ST_OK;
          state_nxt                 = S_DONE;
        end else if (row_r == last_row) begin
          // count at or above the total: reread last row to fetch the last entry
          mode_nxt  = ccct_pkg::MODE_FETCH;
          state_nxt = S_READ;
        end else begin
          row_nxt   = row_r + ccct_pkg::ROW_W'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      mode_r      <= ccct_pkg::MODE_SEARCH;
      used_r      <= '0;
      total_r     <= '0;
      min_value_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      mode_r      <= mode_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        min_value_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.symbol            = out_r.symbol;
  assign out_ch.assoc_value       = out_r.assoc_value;
  assign out_ch.next_context      = out_r.next_context;
  assign out_ch.entry_index       = out_r.entry_index;
  assign out_ch.cum_low           = out_r.cum_low;
  assign out_ch.entry_occurrences = out_r.entry_occurrences;
  assign out_ch.total_count       = out_r.total_count;
  assign out_ch.status            = out_r.status;

endmodule

// ===== rtl/ccct_checker.sv =====
module ccct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_symbol,
  input logic [7:0]  out_index,
  input logic [15:0] out_occ,
  input logic [23:0] out_total,
  input logic [1:0]  out_status
);

  // a stalled result transfer keeps its result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_total)
                                && $stable(out_index))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ccct_pkg::ST_OK) || (out_status == ccct_pkg::ST_FULL)
                  || (out_status == ccct_pkg::ST_EMPTY))
    else $error("unused status code");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ccct_pkg::ST_EMPTY) |->
      (out_total == 24'd0) && (out_index == 8'd0) && (out_occ == 16'd0)
      && (out_symbol == 32'd0))
    else $error("empty-table result carries entry data");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ccct_pkg::ST_FULL) |->
      (out_index == 8'd0) && (out_occ == 16'd0) && (out_symbol == 32'd0))
    else $error("full-table result carries entry data");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cumulative_count_context_table_unit ccct_checker u_ccct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_index  (out_ch.entry_index),
  .out_occ    (out_ch.entry_occurrences),
  .out_total  (out_ch.total_count),
  .out_status (out_ch.status)
);

// ===== test/cumulative_count_context_table_unit_tb.sv =====
`timescale 1ns / 1ps

module cumulative_count_context_table_unit_tb;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          FILL_PHASE   = 3;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          MAX_GAP      = 6;
  localparam logic [31:0] SYMBOL_BIAS  = 32'd2;

  typedef struct {
    logic [1:0]     op;
    logic [31:0]    sym;
    logic [15:0]    occ;
    logic [31:0]    val;
    logic [31:0]    nxt;
    logic [23:0]    cnt;
    bit             typed;
    ccct_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  ccct_in_if  in_bus ();
  ccct_out_if out_bus ();
  ccct_cfg_if cfg_bus ();

  cumulative_count_context_table_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // shadow copy of the table
  logic [31:0] ent_symbol [ccct_pkg::MAX_ENTRIES];
  logic [15:0] ent_occ    [ccct_pkg::MAX_ENTRIES];
  logic [31:0] ent_value  [ccct_pkg::MAX_ENTRIES];
  logic [31:0] ent_next   [ccct_pkg::MAX_ENTRIES];
  logic [23:0] ent_cum    [ccct_pkg::MAX_ENTRIES];
  int unsigned ent_used   = 0;
  logic [23:0] ent_total  = '0;
  logic [31:0] offset_reg = '0;

  ccct_pkg::res_t replies_due [$];
  stim_row_t      directed [$];

  bit no_idle     = 1'b0;
  int errors      = 0;
  int idle_cycles = 0;
  int n_items     = 0;
  int n_checked   = 0;
  int n_append    = 0;
  int n_full      = 0;
  int n_lookup    = 0;
  int n_past      = 0;
  int n_empty     = 0;
  int n_clear     = 0;
  int n_cfg       = 0;

  function automatic ccct_pkg::res_t make_res(logic [31:0] s, logic [31:0] v, logic [31:0] n,
                                              logic [7:0] idx, logic [23:0] cl,
                                              logic [15:0] oc, logic [23:0] tot,
                                              logic [1:0] st);
    ccct_pkg::res_t r;
    r.symbol            = s;
    r.assoc_value       = v;
    r.next_context      = n;
    r.entry_index       = idx;
    r.cum_low           = cl;
    r.entry_occurrences = oc;
    r.total_count       = tot;
    r.status            = st;
    return r;
  endfunction

  function automatic ccct_pkg::res_t entry_fields(int unsigned k);
    ccct_pkg::res_t r;
    r = make_res(ent_symbol[k], ent_value[k], ent_next[k], k[7:0], ent_cum[k], ent_occ[k],
                 '0, ccct_pkg::ST_OK);
    return r;
  endfunction

  // applies one transfer to the shadow table and returns the reply it should produce
  function automatic ccct_pkg::res_t entry_reply(stim_row_t it);
    ccct_pkg::res_t r;
    int unsigned    i;
    int unsigned    hit;
    bit             found;
    logic [24:0]    range_end;
    r     = '0;
    found = 1'b0;
    case (it.op)
      ccct_pkg::OP_CLEAR: begin
        ent_used  = 0;
        ent_total = '0;
        n_clear++;
      end
      ccct_pkg::OP_APPEND: begin
        if (ent_used >= ccct_pkg::MAX_ENTRIES) begin
          r.status = ccct_pkg::ST_FULL;
          n_full++;
        end else begin
          ent_symbol[ent_used] = it.sym - SYMBOL_BIAS;
          ent_occ[ent_used]    = it.occ;
          ent_value[ent_used]  = it.val + offset_reg;
          ent_next[ent_used]   = it.nxt;
          ent_cum[ent_used]    = ent_total;
          ent_total            = ent_total + it.occ;
          r                    = entry_fields(ent_used);
          ent_used++;
          n_append++;
        end
      end
      ccct_pkg::OP_LOOKUP: begin
        if (ent_used == 0) begin
          r.status = ccct_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          hit = ent_used - 1;
          for (i = 0; i < ent_used && !found; i++) begin
            range_end = {1'b0, ent_cum[i]} + ent_occ[i];
            if ({1'b0, it.cnt} < range_end) begin
              hit   = i;
              found = 1'b1;
            end
          end
          if (!found) n_past++;
          r = entry_fields(hit);
          n_lookup++;
        end
      end
      ccct_pkg::OP_NOP: ;
    endcase
    r.total_count = ent_total;
    return r;
  endfunction

  function automatic logic [15:0] pick_occ();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 16'd0;
    if (sel < 20) return 16'hFFFF;
    if (sel < 60) return 16'($urandom_range(1, 15));
    return 16'($urandom);
  endfunction

  // aims mostly at range edges of stored entries
  function automatic logic [23:0] pick_lookup_count();
    int unsigned k;
    int          sel;
    logic [24:0] range_end;
    if (ent_used == 0) return 24'($urandom);
    k         = $urandom_range(0, ent_used - 1);
    range_end = {1'b0, ent_cum[k]} + ent_occ[k];
    sel       = $urandom_range(0, 99);
    if (sel < 25) return ent_cum[k];
    if (sel < 45) return 24'(range_end - 25'd1);
    if (sel < 60) return range_end[23:0];
    if (sel < 70) return ent_total;
    if (sel < 80) return ent_total + 24'($urandom_range(1, 1000));
    if (sel < 90) return 24'($urandom);
    if (sel < 95) return 24'd0;
    return 24'hFFFFFF;
  endfunction

  task automatic add_row(logic [1:0] op, logic [31:0] sym, logic [15:0] occ, logic [31:0] val,
                         logic [31:0] nxt, logic [23:0] cnt, bit typed, ccct_pkg::res_t want);
    stim_row_t r;
    r.op    = op;
    r.sym   = sym;
    r.occ   = occ;
    r.val   = val;
    r.nxt   = nxt;
    r.cnt   = cnt;
    r.typed = typed;
    r.want  = want;
    directed = {directed, r};
  endtask

  // valid stays high after a transfer so back-to-back items need no gap
  task automatic apply_item(stim_row_t it);
    int             gap;
    ccct_pkg::res_t exp;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.operation        <= it.op;
    in_bus.raw_symbol       <= it.sym;
    in_bus.occurrence_count <= it.occ;
    in_bus.raw_value        <= it.val;
    in_bus.next_context_in  <= it.nxt;
    in_bus.lookup_count     <= it.cnt;
    do @(posedge clk); while (!in_bus.ready);
    exp = entry_reply(it);
    if (it.typed) exp = it.want;
    replies_due = {replies_due, exp};
    if (it.op != ccct_pkg::OP_NOP) n_items++;
  endtask

  task automatic random_item(logic [1:0] op);
    stim_row_t r;
    r.op    = op;
    r.sym   = $urandom;
    r.occ   = pick_occ();
    r.val   = $urandom;
    r.nxt   = $urandom;
    r.cnt   = pick_lookup_count();
    r.typed = 1'b0;
    r.want  = '0;
    apply_item(r);
  endtask

  task automatic drain_replies();
    in_bus.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(logic [31:0] v);
    drain_replies();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    offset_reg = v;
    n_cfg++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ccct_pkg::res_t exp;
    if (out_bus.valid && out_bus.ready) begin
      if (replies_due.size() == 0) begin
        $error("result transfer with nothing pending");
        errors++;
      end else begin
        exp = replies_due.pop_front();
        n_checked++;
        check_field("symbol", exp.symbol, out_bus.symbol);
        check_field("assoc_value", exp.assoc_value, out_bus.assoc_value);
        check_field("next_context", exp.next_context, out_bus.next_context);
        check_field("entry_index", exp.entry_index, out_bus.entry_index);
        check_field("cum_low", exp.cum_low, out_bus.cum_low);
        check_field("entry_occurrences", exp.entry_occurrences, out_bus.entry_occurrences);
        check_field("total_count", exp.total_count, out_bus.total_count);
        check_field("status", exp.status, out_bus.status);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("cumulative_count_context_table_unit verification failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin
    logic [31:0] extremes [4];
    int          phase;
    int          n_app;
    int          n_look;
    int          k;
    extremes[0] = 32'h8000_0000;
    extremes[1] = 32'h7FFF_FFFF;
    extremes[2] = 32'hFFFF_FFFF;
    extremes[3] = 32'h0000_0000;

    rst_n                   <= 1'b0;
    in_bus.valid            <= 1'b0;
    in_bus.operation        <= ccct_pkg::OP_NOP;
    in_bus.raw_symbol       <= '0;
    in_bus.occurrence_count <= '0;
    in_bus.raw_value        <= '0;
    in_bus.next_context_in  <= '0;
    in_bus.lookup_count     <= '0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.data            <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, min_value still at its reset value
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b1,
            make_res(0, 0, 0, 0, 0, 0, 0, ccct_pkg::ST_EMPTY));
    add_row(ccct_pkg::OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            24'hFFFFFF, 1'b1, make_res(0, 0, 0, 0, 0, 0, 0, ccct_pkg::ST_OK));
    add_row(ccct_pkg::OP_APPEND, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b1,
            make_res(32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0, ccct_pkg::ST_OK));
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_APPEND, 32'h1, 16'h1, 32'h8000_0000, 32'h5A5A_5A5A, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_APPEND, 32'h2, 16'h3, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h00FFFE, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h00FFFF, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h010000, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h010002, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h010003, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'hFFFFFF, 1'b0, '0);
    add_row(ccct_pkg::OP_APPEND, 32'h8000_0001, 16'h0, 32'h1, 32'h0, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h010003, 1'b0, '0);
    add_row(ccct_pkg::OP_NOP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b0, '0);
    add_row(ccct_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            24'hFFFFFF, 1'b1, make_res(0, 0, 0, 0, 0, 0, 0, ccct_pkg::ST_OK));
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'hFFFFFF, 1'b1,
            make_res(0, 0, 0, 0, 0, 0, 0, ccct_pkg::ST_EMPTY));
    add_row(ccct_pkg::OP_APPEND, 32'h2, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0, 1'b1,
            make_res(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 24'h00FFFF,
                     ccct_pkg::ST_OK));
    add_row(ccct_pkg::OP_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 24'h0, 1'b0, '0);
    foreach (directed[i]) apply_item(directed[i]);

    // random phases: mostly clear, a run of appends, then lookups
    phase = 0;
    while (n_items < directed.size() + RANDOM_ITEMS) begin
      if (phase < 4)
        write_offset(extremes[phase]);
      else if ($urandom_range(0, 2) == 0)
        write_offset(($urandom_range(0, 3) == 0) ? extremes[$urandom_range(0, 3)] : $urandom);
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) != 0) random_item(ccct_pkg::OP_CLEAR);
      if ($urandom_range(0, 6) == 0) random_item(ccct_pkg::OP_LOOKUP);
      n_app = (phase == FILL_PHASE) ? ccct_pkg::MAX_ENTRIES + $urandom_range(1, 4)
                                    : $urandom_range(1, 24);
      for (k = 0; k < n_app; k++) begin
        random_item(ccct_pkg::OP_APPEND);
        if ($urandom_range(0, 3) == 0) random_item(ccct_pkg::OP_LOOKUP);
        if ($urandom_range(0, 29) == 0) random_item(ccct_pkg::OP_NOP);
      end
      n_look = $urandom_range(4, 20);
      for (k = 0; k < n_look; k++) begin
        random_item(ccct_pkg::OP_LOOKUP);
        if ($urandom_range(0, 19) == 0) random_item(ccct_pkg::OP_NOP);
      end
      if ($urandom_range(0, 3) == 0) drain_replies();
      phase++;
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items over %0d phases: %0d appends (%0d refused full), %0d clears",
             n_items, phase, n_append, n_full, n_clear);
    $display("%0d lookups (%0d past total, %0d on empty), %0d min_value writes, %0d checked",
             n_lookup, n_past, n_empty, n_cfg, n_checked);
    if (errors == 0 && replies_due.size() == 0)
      $display("cumulative_count_context_table_unit verification clean");
    else
      $display("cumulative_count_context_table_unit verification failed");
    $finish;
  end

endmodule
